/* src/tts_pkg.sv */
// ----------------------------------------------------------------------------
// Tick timer slot bank package
// Shared types and constants for the slot cells and the top level.
// ----------------------------------------------------------------------------
package tts_pkg;

    // Widths fixed by the event and result formats.
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned IVAL_W     = 32;
    localparam int unsigned REQ_W      = 32;
    localparam int unsigned MASK_W     = 8;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned USED_W     = 4;
    localparam int unsigned TOTAL_W    = 64;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned IN_DATA_W  = IVAL_W + REQ_W;
    localparam int unsigned OUT_DATA_W = 160;

    // Event kinds.
    localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REGISTER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ONESHOT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_STOP     = 2'd3;

    // Timer modes.
    localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ONESHOT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STOPPED  = 2'd2;

    // Largest count the counter hardware takes.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Command broadcast along the row of slot cells.
    typedef struct packed {
        logic              tick;
        logic              enroll;
        logic [IVAL_W-1:0] interval;
    } t_cell_cmd;

    // One result word, first field in the highest bits.
    typedef struct packed {
        logic [COUNT_W-1:0] reload_count;
        logic               reload_oneshot;
        logic               reprogram;
        logic [MODE_W-1:0]  timer_mode;
        logic [TOTAL_W-1:0] idle_total;
        logic [TOTAL_W-1:0] tick_total;
        logic [IDX_W-1:0]   slot_index;
        logic               status;
        logic [MASK_W-1:0]  fired_mask;
    } t_result;

endpackage

/* src/tts_slot_cell.sv */
// ----------------------------------------------------------------------------
// Tick timer slot cell
// One timer slot: interval, counter and in-use flag. A claim signal runs
// along the row so that a registration lands in the first free cell.
// ----------------------------------------------------------------------------
module tts_slot_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tts_pkg::t_cell_cmd i_cmd,
    input  logic               i_claim,
    output logic               o_claim,
    output logic               o_fire
);
    import tts_pkg::*;

    logic              r_used;
    logic [IVAL_W-1:0] r_interval;
    logic [IVAL_W-1:0] r_counter;
    logic [IVAL_W-1:0] n_counter_inc;
    logic              w_take;

    // This cell takes a registration when it is free and no earlier cell has.
    assign w_take  = i_cmd.enroll & ~r_used & ~i_claim;
    assign o_claim = i_claim | w_take;

    // The counter advances on a tick and fires once it reaches the interval.
    assign n_counter_inc = r_counter + IVAL_W'(1);
    assign o_fire        = i_cmd.tick & r_used & (n_counter_inc >= r_interval);

    // Control state: in-use flag and counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= 1'b0;
            r_counter <= '0;
        end else if (w_take) begin
            r_used    <= 1'b1;
            r_counter <= '0;
        end else if (i_cmd.tick && r_used) begin
            r_counter <= o_fire ? '0 : n_counter_inc;
        end
    end

    // The interval is payload and is only read once the cell is in use.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_interval <= i_cmd.interval;
        end
    end

endmodule

/* src/tick_timer_slot_bank.sv */
// ----------------------------------------------------------------------------
// Tick timer slot bank
// Software timer bank with tick, slot registration and mode control.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word on the s_axis channel carries one event, its kind in
//   tuser (0 tick, 1 register slot, 2 enter one-shot, 3 stop) and the
//   interval and one-shot count in tdata. Every event gives exactly one
//   result word on the m_axis channel: fired mask, registration status and
//   slot, tick and idle totals, the new mode and any counter reload.
//   The user writes the periodic divisor through i_cfg_we / i_cfg_wdata
//   only while the block is idle; the block itself does not enforce it.
//   The result word is registered, so it appears in the cycle after
//   acceptance. One event is taken per cycle unless the output stalls;
//   the slot cells all update in the same cycle, so the rate is set only
//   by the single output register. When the receiver stalls, the result
//   word is held and s_axis tready drops until it is taken. Reset clears
//   the totals, the mode (periodic), every slot and the divisor.
// ----------------------------------------------------------------------------
module tick_timer_slot_bank #(
    parameter int unsigned NUM_SLOTS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration: periodic divisor.
    input  logic                              i_cfg_we,
    input  logic [tts_pkg::COUNT_W-1:0]       i_cfg_wdata,
    // Event channel.
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata: interval [31:0], oneshot_count [63:32]
    input  logic [tts_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // tuser: kind [1:0]
    input  logic [tts_pkg::KIND_W-1:0]        i_s_axis_tuser,
    // Result channel.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata: fired_mask [7:0], status [8], slot_index [11:9],
    //        tick_total [75:12], idle_total [139:76], timer_mode [141:140],
    //        reprogram [142], reload_oneshot [143], reload_count [159:144]
    output logic [tts_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);
    import tts_pkg::*;

    logic                r_out_valid;
    t_result             r_result;
    t_result             n_result;
    logic [TOTAL_W-1:0]  r_tick_count;
    logic [TOTAL_W-1:0]  r_idle_count;
    logic [TOTAL_W-1:0]  n_tick_count;
    logic [TOTAL_W-1:0]  n_idle_count;
    logic [MODE_W-1:0]   r_mode;
    logic [MODE_W-1:0]   n_mode;
    logic [USED_W-1:0]   r_slots_used;
    logic [USED_W-1:0]   n_slots_used;
    logic [COUNT_W-1:0]  r_divisor;
    logic                w_accept;
    logic                w_full;
    logic [IVAL_W-1:0]   w_interval;
    logic [REQ_W-1:0]    w_request;
    logic [COUNT_W-1:0]  w_clamped;
    t_cell_cmd           w_cmd;
    logic [NUM_SLOTS:0]  w_claim;
    logic [NUM_SLOTS-1:0] w_fire;

    // Handshake: a new word is taken whenever the output register frees up.
    assign o_s_axis_tready = ~r_out_valid | i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid & o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_result;

    assign w_interval = i_s_axis_tdata[IVAL_W-1:0];
    assign w_request  = i_s_axis_tdata[IN_DATA_W-1:IVAL_W];
    assign w_full     = (r_slots_used >= USED_W'(NUM_SLOTS));

    // One-shot count limited to the range the counter hardware accepts.
    always_comb begin
        if (w_request == '0) begin
            w_clamped = COUNT_W'(1);
        end else if (w_request > REQ_W'(COUNT_MAX)) begin
            w_clamped = COUNT_MAX;
        end else begin
            w_clamped = w_request[COUNT_W-1:0];
        end
    end

    // Command broadcast to the row of slot cells.
    assign w_cmd.tick     = w_accept & (i_s_axis_tuser == KIND_TICK);
    assign w_cmd.enroll   = w_accept & (i_s_axis_tuser == KIND_REGISTER) & ~w_full;
    assign w_cmd.interval = w_interval;

    // Row of slot cells with the free-slot claim chained through them.
    assign w_claim[0] = 1'b0;
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        tts_slot_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_claim (w_claim[g]),
            .o_claim (w_claim[g+1]),
            .o_fire  (w_fire[g])
        );
    end

    // Event decode: next totals, mode and the result word.
    always_comb begin
        n_tick_count = r_tick_count;
        n_idle_count = r_idle_count;
        n_mode       = r_mode;
        n_slots_used = r_slots_used;
        n_result     = '0;
        unique case (i_s_axis_tuser)
            KIND_TICK: begin
                n_tick_count        = r_tick_count + TOTAL_W'(1);
                n_result.fired_mask = MASK_W'(w_fire);
                if (r_mode != MODE_PERIODIC) begin
                    n_idle_count = r_idle_count + TOTAL_W'(1);
                    if (r_divisor != '0) begin
                        n_mode                = MODE_PERIODIC;
                        n_result.reprogram    = 1'b1;
                        n_result.reload_count = r_divisor;
                    end
                end
            end
            KIND_REGISTER: begin
                if (w_full) begin
                    n_result.status = 1'b1;
                end else begin
                    n_result.slot_index = r_slots_used[IDX_W-1:0];
                    n_slots_used        = r_slots_used + USED_W'(1);
                end
            end
            KIND_ONESHOT: begin
                n_mode                  = MODE_ONESHOT;
                n_result.reprogram      = 1'b1;
                n_result.reload_oneshot = 1'b1;
                n_result.reload_count   = w_clamped;
            end
            KIND_STOP: begin
                n_mode                  = MODE_STOPPED;
                n_result.reprogram      = 1'b1;
                n_result.reload_oneshot = 1'b1;
                n_result.reload_count   = COUNT_MAX;
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
        n_result.tick_total = n_tick_count;
        n_result.idle_total = n_idle_count;
        n_result.timer_mode = n_mode;
    end

    // Control state and the divisor register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            r_idle_count <= '0;
            r_mode       <= MODE_PERIODIC;
            r_slots_used <= '0;
            r_divisor    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_divisor <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_tick_count <= n_tick_count;
                r_idle_count <= n_idle_count;
                r_mode       <= n_mode;
                r_slots_used <= n_slots_used;
                r_out_valid  <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

endmodule
